/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the termination detect node.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define TTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define TTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* rtl/core/ttd_pkg.sv */
// Types, codes and helper functions of the tree termination detect node.
// No dependencies; used by the cfg interface and every module of the block.
package ttd_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_APP    = 2'd0,
		OP_TOKEN  = 2'd1,
		OP_REPEAT = 2'd2,
		OP_TICK   = 2'd3
	} ttd_op_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_APP    = 3'd1,
		ACT_TOKEN  = 3'd2,
		ACT_REPEAT = 3'd3,
		ACT_TERM   = 3'd4
	} ttd_action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IS_ROOT      = 3'd0,
		REG_CHILD_MASK   = 3'd1,
		REG_SEND_LIMIT   = 3'd2,
		REG_START_ACTIVE = 3'd3,
		REG_FIRST_PHASE  = 3'd4
	} ttd_reg_t;

	// One classified event: an optional app message beat followed by an
	// optional second beat (token, termination report or repeat).
	typedef struct packed {
		logic        has_app;
		logic [7:0]  app_dest;
		ttd_action_t act2;
		logic        black;
		logic [7:0]  depth;
		logic [31:0] ctrl_a;
		logic [31:0] ctrl_b;
	} ttd_entry_t;

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [15:0] sat16_inc(input logic [15:0] a);
		return (a == 16'hFFFF) ? 16'hFFFF : a + 16'd1;
	endfunction

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, v[i]};
		end
		return c;
	endfunction

endpackage

/* rtl/core/ttd_if.sv */
// Handshake channel interfaces of the tree termination detect node:
// event input, result output and configuration write. Depends on ttd_pkg.
interface ttd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [2:0]  child_slot;
	logic        token_is_black;
	logic [7:0]  hop_count;
	logic [31:0] child_ctrl_count;
	logic [15:0] phase_length;
	logic [7:0]  neighbour_pick;

	modport source (output valid, op, child_slot, token_is_black, hop_count,
		child_ctrl_count, phase_length, neighbour_pick, input ready);
	modport sink (input valid, op, child_slot, token_is_black, hop_count,
		child_ctrl_count, phase_length, neighbour_pick, output ready);
endinterface

interface ttd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  dest_neighbour;
	logic        sent_black;
	logic [7:0]  depth;
	logic [31:0] ctrl_total;
	logic        last;

	modport source (output valid, action, dest_neighbour, sent_black, depth,
		ctrl_total, last, input ready);
	modport sink (input valid, action, dest_neighbour, sent_black, depth,
		ctrl_total, last, output ready);
endinterface

interface ttd_cfg_if;
	import ttd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/ttd_queue.sv */
// Short queue of classified events between the front and back parts.
// Depends on ttd_pkg for the entry type and depth.
module ttd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ttd_pkg::ttd_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ttd_pkg::ttd_entry_t head
);
	import ttd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ttd_entry_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/ttd_front.sv */
// Front part: holds configuration and node state, takes one event a cycle unless
// held off, updates state, pushes classified results. Depends on ttd_pkg, ttd_if.
module ttd_front #(
	parameter int MAX_CHILDREN = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	ttd_req_if.sink             req,
	ttd_cfg_if.sink             cfg,
	input  logic                q_full,
	output logic                push,
	output ttd_pkg::ttd_entry_t push_entry
);
	import ttd_pkg::*;

	localparam logic [7:0] SLOT_MASK = (MAX_CHILDREN >= 8) ? 8'hFF :
		8'((1 << MAX_CHILDREN) - 1);

	// configuration
	logic        is_root_q;
	logic [7:0]  child_mask_q;
	logic [15:0] send_limit_q;

	// node state
	logic        active_q, black_q, detect_q;
	logic [7:0]  heard_q, max_hop_q;
	logic [31:0] own_ctrl_q, kids_ctrl_q;
	logic [15:0] phase_sent_q, phase_target_q, total_sent_q;

	logic        n_active, n_black, n_detect;
	logic [7:0]  n_heard, n_max_hop;
	logic [31:0] n_own_ctrl, n_kids_ctrl;
	logic [15:0] n_phase_sent, n_phase_target, n_total_sent;
	logic        chk;
	logic [7:0]  kids;
	logic [7:0]  hop_up;
	ttd_entry_t  e;

	// hold off events while a register write goes in
	assign kids      = child_mask_q & SLOT_MASK;
	assign req.ready = !q_full && !cfg.valid;
	assign cfg.ready = 1'b1;
	assign push      = req.valid && !q_full && !cfg.valid;
	assign push_entry = e;

	always_comb begin
		n_active       = active_q;
		n_black        = black_q;
		n_detect       = detect_q;
		n_heard        = heard_q;
		n_max_hop      = max_hop_q;
		n_own_ctrl     = own_ctrl_q;
		n_kids_ctrl    = kids_ctrl_q;
		n_phase_sent   = phase_sent_q;
		n_phase_target = phase_target_q;
		n_total_sent   = total_sent_q;
		chk            = 1'b0;
		hop_up         = '0;
		e              = '0;
		e.act2         = ACT_NONE;

		case (req.op)
			OP_APP: begin
				if (!active_q && total_sent_q < send_limit_q) begin
					n_active       = 1'b1;
					n_phase_sent   = '0;
					n_phase_target = req.phase_length;
				end
			end
			OP_TOKEN: begin
				if (req.hop_count > max_hop_q) n_max_hop = req.hop_count;
				n_kids_ctrl = sat32(kids_ctrl_q, req.child_ctrl_count);
				if (req.token_is_black) n_black = 1'b1;
				if ({29'd0, req.child_slot} < 32'(MAX_CHILDREN)) begin
					n_heard = heard_q | (8'd1 << req.child_slot);
				end
				chk = 1'b1;
			end
			OP_REPEAT: begin
				n_detect    = 1'b1;
				n_black     = 1'b0;
				n_heard     = '0;
				n_max_hop   = '0;
				n_kids_ctrl = '0;
				n_own_ctrl  = sat32(own_ctrl_q, {28'd0, popcount8(kids)});
				if (kids != '0) e.act2 = ACT_REPEAT;
			end
			OP_TICK: begin
				if (!active_q) begin
					chk = 1'b1;
				end else begin
					e.has_app    = 1'b1;
					e.app_dest   = req.neighbour_pick;
					n_black      = 1'b1;
					n_phase_sent = sat16_inc(phase_sent_q);
					n_total_sent = sat16_inc(total_sent_q);
					if (n_phase_sent >= phase_target_q || n_total_sent >= send_limit_q) begin
						n_active = 1'b0;
						chk      = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// completion: passive, detecting and every child slot heard
		if (chk && !n_active && n_detect && ((n_heard & kids) == kids)) begin
			n_heard = '0;
			if (!is_root_q) begin
				hop_up     = (kids != '0) ? n_max_hop : 8'd0;
				hop_up     = (hop_up == 8'hFF) ? 8'hFF : hop_up + 8'd1;
				n_own_ctrl = sat32(own_ctrl_q, 32'd1);
				e.act2     = ACT_TOKEN;
				e.black    = n_black;
				e.depth    = hop_up;
				e.ctrl_a   = n_own_ctrl;
				e.ctrl_b   = n_kids_ctrl;
				n_black    = 1'b0;
				n_detect   = 1'b0;
			end else if (!n_black) begin
				e.act2   = ACT_TERM;
				e.ctrl_a = n_own_ctrl;
				e.ctrl_b = n_kids_ctrl;
				n_detect = 1'b0;
			end else begin
				n_own_ctrl  = sat32(own_ctrl_q, {28'd0, popcount8(kids)});
				if (kids != '0) e.act2 = ACT_REPEAT;
				n_black     = 1'b0;
				n_kids_ctrl = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_root_q      <= 1'b0;
			child_mask_q   <= '0;
			send_limit_q   <= '0;
			active_q       <= 1'b0;
			black_q        <= 1'b0;
			detect_q       <= 1'b1;
			heard_q        <= '0;
			max_hop_q      <= '0;
			own_ctrl_q     <= '0;
			kids_ctrl_q    <= '0;
			phase_sent_q   <= '0;
			phase_target_q <= 16'd1;
			total_sent_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IS_ROOT:      is_root_q    <= cfg.data[0];
				REG_CHILD_MASK:   child_mask_q <= cfg.data[7:0];
				REG_SEND_LIMIT:   send_limit_q <= cfg.data;
				REG_START_ACTIVE: begin
					active_q     <= cfg.data[0];
					phase_sent_q <= '0;
				end
				REG_FIRST_PHASE:  phase_target_q <= cfg.data;
				default: ;
			endcase
		end else if (push) begin
			active_q       <= n_active;
			black_q        <= n_black;
			detect_q       <= n_detect;
			heard_q        <= n_heard;
			max_hop_q      <= n_max_hop;
			own_ctrl_q     <= n_own_ctrl;
			kids_ctrl_q    <= n_kids_ctrl;
			phase_sent_q   <= n_phase_sent;
			phase_target_q <= n_phase_target;
			total_sent_q   <= n_total_sent;
		end
	end

endmodule

/* rtl/core/ttd_back.sv */
// Back part: drains classified events from the queue into one or two result
// beats through a registered output. Depends on ttd_pkg, ttd_if.
module ttd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ttd_pkg::ttd_entry_t head,
	output logic                pop,
	ttd_rsp_if.source           rsp
);
	import ttd_pkg::*;

	logic        valid_q;
	logic        second_q;
	logic [2:0]  action_q;
	logic [7:0]  dest_q;
	logic        black_q;
	logic [7:0]  depth_q;
	logic [31:0] ctrl_q;
	logic        last_q;

	logic        load, split, app_beat;

	assign load     = !valid_q || rsp.ready;
	assign split    = head.has_app && (head.act2 != ACT_NONE);
	assign app_beat = head.has_app && !second_q;
	assign pop      = head_valid && load && (!app_beat || !split);

	assign rsp.valid          = valid_q;
	assign rsp.action         = action_q;
	assign rsp.dest_neighbour = dest_q;
	assign rsp.sent_black     = black_q;
	assign rsp.depth          = depth_q;
	assign rsp.ctrl_total     = ctrl_q;
	assign rsp.last           = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q  <= head_valid;
			if (head_valid) second_q <= app_beat && split;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			if (app_beat) begin
				action_q <= ACT_APP;
				dest_q   <= head.app_dest;
				black_q  <= 1'b0;
				depth_q  <= '0;
				ctrl_q   <= '0;
				last_q   <= !split;
			end else begin
				action_q <= head.act2;
				dest_q   <= '0;
				black_q  <= head.black;
				depth_q  <= head.depth;
				ctrl_q   <= sat32(head.ctrl_a, head.ctrl_b);
				last_q   <= 1'b1;
			end
		end
	end

endmodule

/* rtl/core/tree_termination_detect_node.sv */
// Top level of one spanning-tree termination detection node.
// Depends on ttd_pkg, ttd_if, ttd_front, ttd_queue, ttd_back.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | op, child_slot, token_is_black, hop_count,
//          |     |               | child_ctrl_count, phase_length,
//          |     |               | neighbour_pick
//  rsp     | out | valid / ready | action, dest_neighbour, sent_black, depth,
//          |     |               | ctrl_total, last
//  cfg     | in  | valid / ready | index, data (ready always high)
//
// An event is classified and the node state updated in the cycle it is taken,
// so one event enters per cycle while req is ready. Each event gives one
// result beat, or two when a tick both sends an app message and completes
// detection; the back part sends one beat per cycle unless rsp stalls, which
// sets the output rate. A two-entry queue separates the parts and the output
// is registered, so a stalled rsp holds the back while the front takes events
// until the queue fills. Reset is asynchronous and needs no clearing pass.
module tree_termination_detect_node #(
	parameter int MAX_CHILDREN = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	ttd_req_if.sink   req,
	ttd_cfg_if.sink   cfg,
	ttd_rsp_if.source rsp
);
	import ttd_pkg::*;

	// front to queue
	logic       push;
	ttd_entry_t push_entry;
	logic       q_full;

	// queue to back
	logic       head_valid;
	ttd_entry_t head;
	logic       pop;

	// classify events and advance node state
	ttd_front #(
		.MAX_CHILDREN(MAX_CHILDREN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// hold classified events while the output stalls
	ttd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// split each event into its result beats and drive rsp
	ttd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

/* rtl/core/ttd_checker.sv */
// Port-level checker of the tree termination detect node and its bind.
// Depends on ttd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ttd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_action,
	input logic [7:0]  rsp_dest,
	input logic [7:0]  rsp_depth,
	input logic [31:0] rsp_ctrl,
	input logic        rsp_last
);
	import ttd_pkg::*;

	// only an app message beat can be followed by a second beat of its event
	`TTD_ASSERT_IMP(a_nonlast_is_app, clk, arst_n, rsp_valid && !rsp_last, rsp_action == ACT_APP)

	// a beat with no action stands alone and carries nothing
	`TTD_ASSERT_IMP(a_none_alone, clk, arst_n, rsp_valid && rsp_action == ACT_NONE, rsp_last && rsp_ctrl == 32'd0 && rsp_depth == 8'd0)

	// destination only on app beats, depth only on token beats
	`TTD_ASSERT_IMP(a_field_use, clk, arst_n, rsp_valid && rsp_action != ACT_APP, rsp_dest == 8'd0 && (rsp_action == ACT_TOKEN || rsp_depth == 8'd0))

	// a stalled beat holds
	`TTD_ASSERT_NXT(a_stall_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_action) && $stable(rsp_ctrl) && $stable(rsp_last))

endmodule

bind tree_termination_detect_node ttd_checker u_ttd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_action (rsp.action),
	.rsp_dest   (rsp.dest_neighbour),
	.rsp_depth  (rsp.depth),
	.rsp_ctrl   (rsp.ctrl_total),
	.rsp_last   (rsp.last)
);

/* dv/ttd_node_checker.sv */
// Checker for the tree termination detect node: mirrors the node state from
// event and register beats and compares each result beat in order.
// Depends on ttd_pkg and the channel interfaces of ttd_if.
module ttd_node_checker #(
	parameter int MAX_CHILDREN = 8
) (
	input  logic clk,
	input  logic arst_n,
	ttd_req_if   req,
	ttd_rsp_if   rsp,
	ttd_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ttd_pkg::*;

	typedef struct packed {
		ttd_action_t action;
		logic [7:0]  dest;
		logic        black;
		logic [7:0]  depth;
		logic [31:0] ctrl;
		logic        last;
	} node_beat_t;

	localparam logic [7:0] SLOT_MASK =
		(MAX_CHILDREN >= 8) ? 8'hFF : 8'((1 << MAX_CHILDREN) - 1);

	// register copies
	logic        is_root_q;
	logic [7:0]  child_mask_q;
	logic [15:0] send_limit_q;
	logic        start_active_q;
	logic [15:0] first_phase_q;

	// node state
	logic        active;
	logic        token_black;
	logic        detecting;
	logic [7:0]  heard;
	logic [7:0]  max_hop;
	logic [31:0] own_ctrl;
	logic [31:0] children_ctrl;
	logic [15:0] phase_sent;
	logic [15:0] phase_target;
	logic [15:0] total_sent;

	node_beat_t  event_results[$];
	node_beat_t  owed_results[$];

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [15:0] bump16(input logic [15:0] a);
		return (a == 16'hFFFF) ? a : a + 16'd1;
	endfunction

	function automatic logic [31:0] ones8(input logic [7:0] v);
		logic [31:0] c;
		c = '0;
		foreach (v[i]) c = c + 32'(v[i]);
		return c;
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic add_beat(input ttd_action_t act, input logic [7:0] dest,
		input logic blk, input logic [7:0] dep, input logic [31:0] ctrl);
		node_beat_t b;
		b.action = act;
		b.dest   = dest;
		b.black  = blk;
		b.depth  = dep;
		b.ctrl   = ctrl;
		b.last   = 1'b0;
		event_results = {event_results, b};
	endtask

	task automatic clear_node();
		is_root_q      = 1'b0;
		child_mask_q   = '0;
		send_limit_q   = '0;
		start_active_q = 1'b0;
		first_phase_q  = 16'd1;
		active         = start_active_q;
		token_black    = 1'b0;
		detecting      = 1'b1;
		heard          = '0;
		max_hop        = '0;
		own_ctrl       = '0;
		children_ctrl  = '0;
		phase_sent     = '0;
		phase_target   = first_phase_q;
		total_sent     = '0;
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_IS_ROOT:    is_root_q = data[0];
			REG_CHILD_MASK: child_mask_q = data[7:0];
			REG_SEND_LIMIT: send_limit_q = data;
			REG_START_ACTIVE: begin
				start_active_q = data[0];
				active         = data[0];
				phase_sent     = '0;
			end
			REG_FIRST_PHASE: begin
				first_phase_q = data;
				phase_target  = data;
			end
			default: ;
		endcase
	endtask

	task automatic send_repeat();
		logic [7:0] kids;
		kids = child_mask_q & SLOT_MASK;
		own_ctrl = add_sat(own_ctrl, ones8(kids));
		if (kids != 0) add_beat(ACT_REPEAT, '0, 1'b0, '0, '0);
	endtask

	// Passive, detecting and all children heard: report upward or decide at the root.
	task automatic try_complete();
		logic [7:0] kids;
		logic [7:0] d;
		kids = child_mask_q & SLOT_MASK;
		if (active || !detecting || (heard & kids) != kids) return;
		heard = '0;
		if (!is_root_q) begin
			d = (kids != 0) ? max_hop : 8'd0;
			d = (d == 8'hFF) ? d : d + 8'd1;
			own_ctrl = add_sat(own_ctrl, 32'd1);
			add_beat(ACT_TOKEN, '0, token_black, d, add_sat(own_ctrl, children_ctrl));
			token_black = 1'b0;
			detecting   = 1'b0;
		end else if (!token_black) begin
			add_beat(ACT_TERM, '0, 1'b0, '0, add_sat(own_ctrl, children_ctrl));
			detecting = 1'b0;
		end else begin
			send_repeat();
			token_black   = 1'b0;
			children_ctrl = '0;
		end
	endtask

	task automatic advance_node(input ttd_op_t op, input logic [2:0] slot, input logic blk,
		input logic [7:0] hop, input logic [31:0] cc, input logic [15:0] plen,
		input logic [7:0] pick);
		event_results.delete();
		case (op)
			OP_APP: begin
				if (!active && total_sent < send_limit_q) begin
					active       = 1'b1;
					phase_sent   = '0;
					phase_target = plen;
				end
			end
			OP_TOKEN: begin
				if (hop > max_hop) max_hop = hop;
				children_ctrl = add_sat(children_ctrl, cc);
				if (blk) token_black = 1'b1;
				if (int'(slot) < MAX_CHILDREN) heard = heard | (8'd1 << slot);
				try_complete();
			end
			OP_REPEAT: begin
				detecting     = 1'b1;
				token_black   = 1'b0;
				heard         = '0;
				max_hop       = '0;
				children_ctrl = '0;
				send_repeat();
			end
			OP_TICK: begin
				if (!active) begin
					try_complete();
				end else begin
					add_beat(ACT_APP, pick, 1'b0, '0, '0);
					token_black = 1'b1;
					phase_sent  = bump16(phase_sent);
					total_sent  = bump16(total_sent);
					if (phase_sent >= phase_target || total_sent >= send_limit_q) begin
						active = 1'b0;
						try_complete();
					end
				end
			end
			default: ;
		endcase
		if (event_results.size() == 0) add_beat(ACT_NONE, '0, 1'b0, '0, '0);
		event_results[event_results.size() - 1].last = 1'b1;
		foreach (event_results[i]) owed_results = {owed_results, event_results[i]};
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		node_beat_t want;
		int         errs;
		if (!arst_n) begin
			clear_node();
			owed_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg.valid && cfg.ready) write_register(cfg.index, cfg.data);
			if (req.valid && req.ready) begin
				advance_node(ttd_op_t'(req.op), req.child_slot, req.token_is_black,
					req.hop_count, req.child_ctrl_count, req.phase_length, req.neighbour_pick);
			end
			if (rsp.valid && rsp.ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, action %0d",
						$time, rsp.action);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					errs = 0;
					errs += field_diff("action", 32'(want.action), 32'(rsp.action));
					errs += field_diff("dest_neighbour", 32'(want.dest),
						32'(rsp.dest_neighbour));
					errs += field_diff("sent_black", 32'(want.black), 32'(rsp.sent_black));
					errs += field_diff("depth", 32'(want.depth), 32'(rsp.depth));
					errs += field_diff("ctrl_total", want.ctrl, rsp.ctrl_total);
					errs += field_diff("last", 32'(want.last), 32'(rsp.last));
					if (errs != 0) fail_count++;
				end
			end
			pending = owed_results.size();
		end
	end

endmodule

/* dv/tree_termination_detect_node_tb.sv */
// Testbench top of the tree termination detect node: clock, reset, event and
// register stimulus, result back-pressure and the verdict.
// Depends on ttd_pkg, ttd_if, the node RTL and ttd_node_checker.
module tree_termination_detect_node_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ttd_pkg::*;

	localparam int NODE_CHILDREN   = 8;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 125;
	// receiver hold-off that fills the internal queue and stalls the event input
	localparam int LONG_HOLD       = 300;
	// quiet time after the last owed result arrives, before settle returns
	localparam int DRAIN_CYCLES    = 8;
	localparam int RUN_LIMIT_NS    = 5_000_000;
	// index past the register map, which the node must ignore
	localparam logic [CFG_INDEX_W-1:0] UNUSED_REG = 3'd5;

	typedef struct {
		ttd_op_t     op;
		logic [2:0]  slot;
		logic        blk;
		logic [7:0]  hop;
		logic [31:0] cc;
		logic [15:0] plen;
		logic [7:0]  pick;
	} node_event_t;

	logic       clk;
	logic       arst_n;
	int         fail_count;
	int         pending;
	int         items_sent;
	int         send_calm;
	bit         hold_req;
	logic [7:0] cur_mask;

	ttd_req_if req_ch ();
	ttd_rsp_if rsp_ch ();
	ttd_cfg_if cfg_ch ();

	tree_termination_detect_node #(
		.MAX_CHILDREN(NODE_CHILDREN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.cfg(cfg_ch),
		.rsp(rsp_ch)
	);

	ttd_node_checker #(
		.MAX_CHILDREN(NODE_CHILDREN)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Control counts: half small so sums stay readable, often full range,
	// sometimes all ones to hit saturation at once.
	function automatic logic [31:0] pick_ctrl();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return $urandom_range(0, 1000);
		if (r < 9) return $urandom();
		return 32'hFFFF_FFFF;
	endfunction

	// Phase lengths: short phases keep the node cycling between active and
	// passive; zero ends a phase after one message.
	function automatic logic [15:0] pick_phase_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return 16'($urandom_range(1, 6));
		if (r == 7) return 16'd0;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic node_event_t random_event();
		node_event_t e;
		e.op   = ttd_op_t'($urandom_range(0, 3));
		e.slot = 3'($urandom_range(0, 7));
		e.blk  = 1'($urandom_range(0, 1));
		e.hop  = 8'($urandom_range(0, 255));
		e.cc   = pick_ctrl();
		e.plen = pick_phase_len();
		e.pick = 8'($urandom_range(0, 255));
		return e;
	endfunction

	function automatic node_event_t mk_event(input ttd_op_t op, input logic [2:0] slot,
		input logic blk, input logic [7:0] hop, input logic [31:0] cc,
		input logic [15:0] plen, input logic [7:0] pick);
		node_event_t e;
		e.op   = op;
		e.slot = slot;
		e.blk  = blk;
		e.hop  = hop;
		e.cc   = cc;
		e.plen = plen;
		e.pick = pick;
		return e;
	endfunction

	// Offer one event beat, after an optional idle gap, and hold it until taken.
	// Called and left at a falling edge; valid stays high for back-to-back beats.
	task automatic send_event(input node_event_t e);
		int gap;
		int r;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) send_calm = $urandom_range(20, 80);
			gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.op               <= e.op;
		req_ch.child_slot       <= e.slot;
		req_ch.token_is_black   <= e.blk;
		req_ch.hop_count        <= e.hop;
		req_ch.child_ctrl_count <= e.cc;
		req_ch.phase_length     <= e.plen;
		req_ch.neighbour_pick   <= e.pick;
		req_ch.valid            <= 1'b1;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Leaves cfg valid high; apply_setting drops it after the last write.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic root, input logic [7:0] mask,
		input logic [15:0] limit, input logic start, input logic [15:0] phase,
		input bit poke_unused);
		write_reg(REG_IS_ROOT, {15'd0, root});
		write_reg(REG_CHILD_MASK, {8'd0, mask});
		write_reg(REG_SEND_LIMIT, limit);
		write_reg(REG_START_ACTIVE, {15'd0, start});
		write_reg(REG_FIRST_PHASE, phase);
		if (poke_unused) write_reg(UNUSED_REG, 16'($urandom_range(0, 65535)));
		cfg_ch.valid <= 1'b0;
		cur_mask = mask;
	endtask

	// Drop valid, wait for every owed result, then let the pipeline go quiet.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One detection round: optional repeat from the parent, some activity, a
	// token from every child in shuffled order with ticks mixed in, then ticks
	// so the node can go passive and finish.
	task automatic run_round();
		node_event_t e;
		logic [2:0]  order[$];
		logic [2:0]  tmp;
		int          j;
		int          n;
		if ($urandom_range(0, 4) != 0) begin
			e = random_event();
			e.op = OP_REPEAT;
			send_event(e);
		end
		n = $urandom_range(0, 5);
		repeat (n) begin
			e = random_event();
			e.op = ($urandom_range(0, 2) == 0) ? OP_APP : OP_TICK;
			send_event(e);
		end
		for (int s = 0; s < 8; s++) begin
			if (cur_mask[s]) order = {order, 3'(s)};
		end
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			if ($urandom_range(0, 3) == 0) begin
				e = random_event();
				e.op = OP_TICK;
				send_event(e);
			end
			e = random_event();
			e.op   = OP_TOKEN;
			e.slot = order[i];
			e.blk  = ($urandom_range(0, 3) == 0);
			send_event(e);
		end
		n = $urandom_range(1, 4);
		repeat (n) begin
			e = random_event();
			e.op = OP_TICK;
			send_event(e);
		end
	endtask

	initial begin : stimulus
		int          phase_end;
		logic [7:0]  mask;
		logic [15:0] limit;
		logic [15:0] phase;
		arst_n                  = 1'b0;
		hold_req                = 1'b0;
		items_sent              = 0;
		send_calm               = 0;
		cur_mask                = '0;
		req_ch.valid            = 1'b0;
		req_ch.op               = OP_APP;
		req_ch.child_slot       = '0;
		req_ch.token_is_black   = 1'b0;
		req_ch.hop_count        = '0;
		req_ch.child_ctrl_count = '0;
		req_ch.phase_length     = '0;
		req_ch.neighbour_pick   = '0;
		rsp_ch.ready            = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = '0;
		cfg_ch.data             = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: a childless non-root that may never send.
		// A passive tick completes at once and sends a depth-one token.
		send_event(mk_event(OP_TICK, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		// activation blocked by the zero send limit
		send_event(mk_event(OP_APP, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		// repeat with no children: state resets but no repeat message goes out
		send_event(mk_event(OP_REPEAT, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		// black token with an all-ones count from a slot that is not a child
		send_event(mk_event(OP_TOKEN, 3'd7, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
		settle();

		// Root with two children, four messages in all, two per phase.
		apply_setting(1'b1, 8'h03, 16'd4, 1'b1, 16'd2, 1'b0);
		send_event(mk_event(OP_REPEAT, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		send_event(mk_event(OP_TICK, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		send_event(mk_event(OP_TICK, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'hFF));
		send_event(mk_event(OP_TOKEN, 3'd0, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'd1, 8'd0));
		// all heard with a black token: root broadcasts repeat
		send_event(mk_event(OP_TOKEN, 3'd1, 1'b0, 8'd0, 32'd5, 16'd1, 8'd0));
		// token from a slot that is not a child
		send_event(mk_event(OP_TOKEN, 3'd5, 1'b0, 8'd9, 32'd3, 16'd1, 8'd0));
		send_event(mk_event(OP_TOKEN, 3'd0, 1'b0, 8'd3, 32'd10, 16'd1, 8'd0));
		// white root with all heard: termination
		send_event(mk_event(OP_TOKEN, 3'd1, 1'b0, 8'd4, 32'd20, 16'd1, 8'd0));
		// zero phase length: the phase ends after one message
		send_event(mk_event(OP_APP, 3'd0, 1'b0, 8'd0, 32'd0, 16'd0, 8'd0));
		send_event(mk_event(OP_TICK, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'h5A));
		send_event(mk_event(OP_REPEAT, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		send_event(mk_event(OP_APP, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		send_event(mk_event(OP_TOKEN, 3'd0, 1'b0, 8'd1, 32'd1, 16'd1, 8'd0));
		send_event(mk_event(OP_TOKEN, 3'd1, 1'b0, 8'd2, 32'd2, 16'd1, 8'd0));
		// last allowed message also completes detection: two result beats
		send_event(mk_event(OP_TICK, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'hA5));
		settle();

		// Non-root with all eight children; the deepest child saturates depth.
		apply_setting(1'b0, 8'hFF, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1);
		send_event(mk_event(OP_REPEAT, 3'd0, 1'b0, 8'd0, 32'd0, 16'd1, 8'd0));
		for (int s = 0; s < 8; s++) begin
			send_event(mk_event(OP_TOKEN, 3'(s), 1'(s & 1), (s == 7) ? 8'hFF : 8'(s),
				32'h8000_0000, 16'd1, 8'd0));
		end
		settle();

		// Random part; the receiver takes its long hold-off early on.
		hold_req <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: apply_setting(1'b1, 8'h01, 16'd0, 1'b1, 16'd1, 1'b0);
				1: apply_setting(1'b0, 8'hFF, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0);
				2: apply_setting(1'b1, 8'h00, 16'($urandom_range(1, 65535)), 1'b1,
					16'($urandom_range(1, 6)), 1'b0);
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						mask = 8'(1 << $urandom_range(0, 7)) | 8'(1 << $urandom_range(0, 7));
					end else begin
						mask = 8'($urandom_range(0, 255));
					end
					limit = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
					phase = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 6)) :
						16'($urandom_range(1, 65535));
					apply_setting(1'($urandom_range(0, 1)), mask, limit,
						1'($urandom_range(0, 1)), phase, $urandom_range(0, 3) == 0);
				end
			endcase
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 4) != 0) begin
					run_round();
				end else begin
					repeat ($urandom_range(1, 5)) send_event(random_event());
				end
			end
			settle();
		end

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Result side: random idle gaps, calm stretches with ready held high, and
	// one long hold-off once the stimulus asks for it.
	initial begin : rsp_side
		int idle_left;
		int calm_left;
		int hold_left;
		int r;
		bit hold_done;
		idle_left = 0;
		calm_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (idle_left > 0) begin
				rsp_ch.ready <= 1'b0;
				idle_left--;
			end else if (calm_left > 0) begin
				rsp_ch.ready <= 1'b1;
				calm_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 2) calm_left = $urandom_range(50, 200);
				else if (r < 25) idle_left = $urandom_range(1, 3);
				else if (r < 29) idle_left = $urandom_range(8, 40);
			end
		end
	end

	// Give up if the run hangs.
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ttd_pkg.sv
rtl/core/ttd_if.sv
rtl/core/ttd_queue.sv
rtl/core/ttd_front.sv
rtl/core/ttd_back.sv
rtl/core/tree_termination_detect_node.sv
rtl/core/ttd_checker.sv
dv/ttd_node_checker.sv
dv/tree_termination_detect_node_tb.sv
